FILE: rtl/fcpu_pkg.sv
// Shared types, constants and lookup functions for the fly camera pose update block.
`timescale 1ns / 1ps

package fcpu_pkg;

    // Angle and limit constants (angles in 2^-16 degree units)
    localparam logic [24:0]        YAW_FULL     = 25'd23592960;
    localparam logic signed [25:0] ANG_FULL     = 26'sd23592960;
    localparam logic signed [25:0] ANG_HALF     = 26'sd11796480;
    localparam logic signed [25:0] ANG_QUARTER  = 26'sd5898240;
    localparam logic signed [23:0] PITCH_LIMIT  = 24'sd5832704;
    localparam logic signed [31:0] CORDIC_START = 32'sd652032874;
    localparam logic signed [15:0] VEC_ONE      = 16'sd16384;

    // Register reset values
    localparam logic [15:0] SPEED_RESET = 16'd640;
    localparam logic [15:0] SENS_RESET  = 16'd6554;

    // Iteration counts (last step index)
    localparam logic [4:0] CORDIC_LAST = 5'd15;
    localparam logic [4:0] SQRT_LAST   = 5'd31;
    localparam logic [4:0] DIV_LAST    = 5'd31;
    localparam logic [1:0] AXIS_LAST   = 2'd2;

    // Operation codes
    localparam logic OP_MOVE   = 1'b0;
    localparam logic OP_ROTATE = 1'b1;

    typedef enum logic [2:0] {
        DIR_FORWARD,
        DIR_BACKWARD,
        DIR_LEFT,
        DIR_RIGHT,
        DIR_UP,
        DIR_DOWN
    } t_dir;

    typedef enum logic [2:0] {
        CFG_MOVE_SPEED,
        CFG_LOOK_SENS,
        CFG_START_X,
        CFG_START_Y,
        CFG_START_Z,
        CFG_START_YAW,
        CFG_START_PITCH
    } t_cfg_idx;

    // Division jobs of the basis rebuild, in issue order
    typedef enum logic [3:0] {
        DV_FRONT_X,
        DV_FRONT_Y,
        DV_FRONT_Z,
        DV_RIGHT_X,
        DV_RIGHT_Z,
        DV_A,
        DV_C,
        DV_UP_Y,
        DV_UP_X,
        DV_UP_Z
    } t_div_sel;

    // Datapath operations
    typedef enum logic [4:0] {
        DP_NOP,
        DP_MV_VEL,
        DP_MV_MUL,
        DP_MV_ACC,
        DP_ROT_MUL,
        DP_ROT_ADD,
        DP_ROT_WRAP,
        DP_CRD_INIT,
        DP_CRD_STEP,
        DP_FX_MUL,
        DP_FZ_MUL,
        DP_SQ_X,
        DP_SQ_Z,
        DP_SQ_Y,
        DP_SUM,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_UP_MUL,
        DP_DIV_START,
        DP_DIV_STEP,
        DP_DIV_STORE
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [4:0] cnt;
        logic [1:0] axis;
        t_div_sel   div;
    } t_dp_cmd;

    typedef struct packed {
        logic yaw_ok;
    } t_dp_status;

    typedef struct packed {
        logic               op;
        logic [2:0]         direction;
        logic [19:0]        delta_time;
        logic signed [23:0] yaw_offset;
        logic signed [23:0] pitch_offset;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] front_x;
        logic signed [15:0] front_y;
        logic signed [15:0] front_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } t_out_item;

    // Arctangent of 2^-i in 2^-16 degree units
    function automatic logic signed [25:0] atan_lut(input logic [3:0] i);
        logic signed [25:0] v;
        case (i)
            4'd0:    v = 26'sd2949120;
            4'd1:    v = 26'sd1740967;
            4'd2:    v = 26'sd919879;
            4'd3:    v = 26'sd466945;
            4'd4:    v = 26'sd234379;
            4'd5:    v = 26'sd117304;
            4'd6:    v = 26'sd58666;
            4'd7:    v = 26'sd29335;
            4'd8:    v = 26'sd14668;
            4'd9:    v = 26'sd7334;
            4'd10:   v = 26'sd3667;
            4'd11:   v = 26'sd1833;
            4'd12:   v = 26'sd917;
            4'd13:   v = 26'sd458;
            4'd14:   v = 26'sd229;
            default: v = 26'sd115;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/fcpu_ctrl.sv
// Sequencer for the fly camera pose update: steps the datapath through move, rotate and basis.
`timescale 1ns / 1ps

module fcpu_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_acc,
    input  logic                 i_in_op,
    input  logic [2:0]           i_in_dir,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_acc,
    input  logic [2:0]           i_cfg_index,
    input  fcpu_pkg::t_dp_status i_status,
    input  logic                 i_out_free,
    output fcpu_pkg::t_dp_cmd    o_cmd,
    output logic                 o_in_ready,
    output logic                 o_cfg_ready,
    output logic                 o_res_load
);
    import fcpu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MV_VEL,
        S_MV_MUL,
        S_MV_ACC,
        S_ROT_MUL,
        S_ROT_ADD,
        S_ROT_WRAP,
        S_CRD_INIT,
        S_CRD_STEP,
        S_FX_MUL,
        S_FZ_MUL,
        S_SQ_X,
        S_SQ_Z,
        S_SQ_Y,
        S_SUM,
        S_SQRT_INIT,
        S_SQRT_STEP,
        S_UP_MUL,
        S_DIV_START,
        S_DIV_STEP,
        S_DIV_STORE,
        S_RESULT
    } t_state;

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_axis, n_axis;
    t_div_sel   r_div, n_div;
    logic       r_report, n_report;
    t_div_sel   w_div_next;

    assign w_div_next = t_div_sel'(r_div + 4'd1);

    // Next state
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_axis   = r_axis;
        n_div    = r_div;
        n_report = r_report;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_acc) begin
                    if (i_in_op == OP_ROTATE) begin
                        n_state = S_ROT_MUL;
                    end else if (i_in_dir <= DIR_DOWN) begin
                        n_state = S_MV_VEL;
                    end else begin
                        n_state = S_RESULT;
                    end
                end else if (i_cfg_acc && (i_cfg_index == CFG_START_YAW ||
                                           i_cfg_index == CFG_START_PITCH)) begin
                    n_state  = S_CRD_INIT;
                    n_report = 1'b0;
                end
            end
            S_MV_VEL: begin
                n_state = S_MV_MUL;
                n_axis  = 2'd0;
            end
            S_MV_MUL: n_state = S_MV_ACC;
            S_MV_ACC: begin
                if (r_axis == AXIS_LAST) begin
                    n_state = S_RESULT;
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_MV_MUL;
                end
            end
            S_ROT_MUL: n_state = S_ROT_ADD;
            S_ROT_ADD: n_state = S_ROT_WRAP;
            S_ROT_WRAP: begin
                if (i_status.yaw_ok) begin
                    n_state  = S_CRD_INIT;
                    n_report = 1'b1;
                end
            end
            S_CRD_INIT: begin
                n_state = S_CRD_STEP;
                n_cnt   = '0;
            end
            S_CRD_STEP: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == CORDIC_LAST) n_state = S_FX_MUL;
            end
            S_FX_MUL: n_state = S_FZ_MUL;
            S_FZ_MUL: n_state = S_SQ_X;
            S_SQ_X:   n_state = S_SQ_Z;
            S_SQ_Z:   n_state = S_SQ_Y;
            S_SQ_Y:   n_state = S_SUM;
            S_SUM:    n_state = S_SQRT_INIT;
            S_SQRT_INIT: begin
                n_state = S_SQRT_STEP;
                n_cnt   = '0;
            end
            S_SQRT_STEP: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == SQRT_LAST) begin
                    n_state = S_DIV_START;
                    n_div   = DV_FRONT_X;
                end
            end
            S_UP_MUL: n_state = S_DIV_START;
            S_DIV_START: begin
                n_state = S_DIV_STEP;
                n_cnt   = '0;
            end
            S_DIV_STEP: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == DIV_LAST) n_state = S_DIV_STORE;
            end
            S_DIV_STORE: begin
                if (r_div == DV_UP_Z) begin
                    n_state = r_report ? S_RESULT : S_IDLE;
                end else begin
                    n_div   = w_div_next;
                    n_state = (w_div_next == DV_UP_X || w_div_next == DV_UP_Z) ?
                              S_UP_MUL : S_DIV_START;
                end
            end
            S_RESULT: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and counters; reset rebuilds the basis from the start angles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CRD_INIT;
            r_cnt    <= '0;
            r_axis   <= '0;
            r_div    <= DV_FRONT_X;
            r_report <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_axis   <= n_axis;
            r_div    <= n_div;
            r_report <= n_report;
        end
    end

    // Command decode
    always_comb begin
        o_cmd.cnt  = r_cnt;
        o_cmd.axis = r_axis;
        o_cmd.div  = r_div;
        unique case (r_state)
            S_MV_VEL:    o_cmd.op = DP_MV_VEL;
            S_MV_MUL:    o_cmd.op = DP_MV_MUL;
            S_MV_ACC:    o_cmd.op = DP_MV_ACC;
            S_ROT_MUL:   o_cmd.op = DP_ROT_MUL;
            S_ROT_ADD:   o_cmd.op = DP_ROT_ADD;
            S_ROT_WRAP:  o_cmd.op = DP_ROT_WRAP;
            S_CRD_INIT:  o_cmd.op = DP_CRD_INIT;
            S_CRD_STEP:  o_cmd.op = DP_CRD_STEP;
            S_FX_MUL:    o_cmd.op = DP_FX_MUL;
            S_FZ_MUL:    o_cmd.op = DP_FZ_MUL;
            S_SQ_X:      o_cmd.op = DP_SQ_X;
            S_SQ_Z:      o_cmd.op = DP_SQ_Z;
            S_SQ_Y:      o_cmd.op = DP_SQ_Y;
            S_SUM:       o_cmd.op = DP_SUM;
            S_SQRT_INIT: o_cmd.op = DP_SQRT_INIT;
            S_SQRT_STEP: o_cmd.op = DP_SQRT_STEP;
            S_UP_MUL:    o_cmd.op = DP_UP_MUL;
            S_DIV_START: o_cmd.op = DP_DIV_START;
            S_DIV_STEP:  o_cmd.op = DP_DIV_STEP;
            S_DIV_STORE: o_cmd.op = DP_DIV_STORE;
            default:     o_cmd.op = DP_NOP;
        endcase
    end

    // A pending register write goes first, so the two channels never transfer together
    assign o_in_ready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_res_load  = (r_state == S_RESULT) && i_out_free;

`ifndef SYNTHESIS
    a_div_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_MUL) |-> (r_div == DV_UP_X || r_div == DV_UP_Z))
        else $error("up multiply issued for wrong division job");
    a_move_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MV_ACC && r_axis == AXIS_LAST) |=> (r_state == S_RESULT))
        else $error("move did not finish after last axis");
    a_wrap_to_basis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT_WRAP && i_status.yaw_ok) |=> (r_state == S_CRD_INIT && r_report))
        else $error("rotate did not start basis rebuild");
`endif

endmodule

FILE: rtl/fcpu_dp.sv
// Datapath of the fly camera pose update: pose state, CORDIC, square root and divider.
`timescale 1ns / 1ps

module fcpu_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fcpu_pkg::t_in_item   i_item,
    input  logic                 i_in_acc,
    input  logic                 i_cfg_acc,
    input  logic [2:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  fcpu_pkg::t_dp_cmd    i_cmd,
    output fcpu_pkg::t_dp_status o_status,
    output fcpu_pkg::t_out_item  o_pose
);
    import fcpu_pkg::*;

    // Architectural state
    logic [15:0]        r_speed, r_sens;
    logic signed [31:0] r_pos [3];
    logic [24:0]        r_yaw;
    logic signed [23:0] r_pitch;
    logic signed [15:0] r_front [3];
    logic signed [15:0] r_right [3];
    logic signed [15:0] r_up [3];
    t_in_item           r_item;

    // Working registers
    logic [35:0]        r_vel;
    logic signed [52:0] r_mprod;
    logic signed [28:0] r_dy, r_dp;
    logic signed [29:0] r_yt;
    logic signed [31:0] r_cx [2];
    logic signed [31:0] r_cy [2];
    logic signed [25:0] r_cz [2];
    logic               r_cneg [2];
    logic signed [63:0] r_prod;
    logic signed [31:0] r_fx, r_fy, r_fz, r_a, r_c;
    logic [63:0]        r_sumh, r_suml;
    logic [63:0]        r_sv [2];
    logic [63:0]        r_sr [2];
    logic [62:0]        r_sbit;
    logic [31:0]        r_dlow;
    logic [48:0]        r_drem;
    logic [47:0]        r_dden;
    logic               r_dneg;
    logic [31:0]        r_dq;

    function automatic logic signed [15:0] vclamp(input logic signed [32:0] v);
        logic signed [15:0] r;
        if (v > 33'sd16384) r = VEC_ONE;
        else if (v < -33'sd16384) r = -VEC_ONE;
        else r = v[15:0];
        return r;
    endfunction

    // Fold an angle into [-90,90] degrees; top bit flags a removed half turn
    function automatic logic [26:0] reduce_ang(input logic signed [25:0] a_in);
        logic signed [25:0] a;
        logic               neg;
        a   = a_in;
        neg = 1'b0;
        if (a > ANG_HALF) a = a - ANG_FULL;
        if (a > ANG_QUARTER) begin
            a   = a - ANG_HALF;
            neg = 1'b1;
        end else if (a < -ANG_QUARTER) begin
            a   = a + ANG_HALF;
            neg = 1'b1;
        end
        return {neg, a};
    endfunction

    // CORDIC views: lane 0 yaw, lane 1 pitch
    logic [26:0]        w_red [2];
    logic signed [31:0] w_cos [2], w_sin [2];
    logic signed [31:0] w_xs [2], w_ys [2];
    logic signed [25:0] w_atan;

    assign w_red[0] = reduce_ang($signed({1'b0, r_yaw}));
    assign w_red[1] = reduce_ang({{2{r_pitch[23]}}, r_pitch});
    assign w_atan   = atan_lut(i_cmd.cnt[3:0]);

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_cos[l] = r_cneg[l] ? -r_cx[l] : r_cx[l];
            w_sin[l] = r_cneg[l] ? -r_cy[l] : r_cy[l];
            w_xs[l]  = r_cx[l] >>> i_cmd.cnt[3:0];
            w_ys[l]  = r_cy[l] >>> i_cmd.cnt[3:0];
        end
    end

    // Shared basis multiplier
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod, w_prnd;
    logic signed [31:0] w_round30;

    always_comb begin
        case (i_cmd.op)
            DP_FX_MUL: begin w_ma = w_cos[1]; w_mb = w_cos[0]; end
            DP_FZ_MUL: begin w_ma = w_cos[1]; w_mb = w_sin[0]; end
            DP_SQ_X:   begin w_ma = r_fx;     w_mb = r_fx;     end
            DP_SQ_Z:   begin w_ma = r_fz;     w_mb = r_fz;     end
            DP_SQ_Y:   begin w_ma = r_fy;     w_mb = r_fy;     end
            DP_UP_MUL: begin w_ma = (i_cmd.div == DV_UP_X) ? r_a : r_c; w_mb = r_fy; end
            default:   begin w_ma = r_fx;     w_mb = r_fz;     end
        endcase
    end

    assign w_prod    = w_ma * w_mb;
    assign w_prnd    = r_prod + 64'sd536870912;
    assign w_round30 = w_prnd[61:30];

    // Square root lanes: 0 horizontal length, 1 full length
    logic [63:0] w_st [2];
    logic [31:0] w_hlen, w_len;

    always_comb begin
        for (int l = 0; l < 2; l++) w_st[l] = r_sr[l] + {1'b0, r_sbit};
    end

    assign w_hlen = r_sr[0][31:0];
    assign w_len  = r_sr[1][31:0];

    // Divider operand selection
    logic signed [63:0] w_num;
    logic [47:0]        w_den;
    logic [63:0]        w_nabs, w_mag;
    logic [48:0]        w_dsh;
    logic signed [32:0] w_qs;
    logic signed [15:0] w_qv;

    always_comb begin
        case (i_cmd.div)
            DV_FRONT_X: begin w_num = {{18{r_fx[31]}}, r_fx, 14'b0};    w_den = {16'b0, w_len};  end
            DV_FRONT_Y: begin w_num = {{18{r_fy[31]}}, r_fy, 14'b0};    w_den = {16'b0, w_len};  end
            DV_FRONT_Z: begin w_num = {{18{r_fz[31]}}, r_fz, 14'b0};    w_den = {16'b0, w_len};  end
            DV_RIGHT_X: begin w_num = -{{18{r_fz[31]}}, r_fz, 14'b0};   w_den = {16'b0, w_hlen}; end
            DV_RIGHT_Z: begin w_num = {{18{r_fx[31]}}, r_fx, 14'b0};    w_den = {16'b0, w_hlen}; end
            DV_A:       begin w_num = {{2{r_fx[31]}}, r_fx, 30'b0};     w_den = {16'b0, w_hlen}; end
            DV_C:       begin w_num = {{2{r_fz[31]}}, r_fz, 30'b0};     w_den = {16'b0, w_hlen}; end
            DV_UP_Y:    begin w_num = $signed({18'b0, w_hlen, 14'b0}); w_den = {16'b0, w_len};  end
            DV_UP_X:    begin w_num = -r_prod;                         w_den = {w_len, 16'b0};  end
            DV_UP_Z:    begin w_num = -r_prod;                         w_den = {w_len, 16'b0};  end
            default:    begin w_num = '0;                              w_den = '0;              end
        endcase
    end

    // Round half away from zero: magnitude plus half the divisor
    assign w_nabs = w_num[63] ? 64'(-w_num) : 64'(w_num);
    assign w_mag  = w_nabs + {17'b0, w_den[47:1]};
    assign w_dsh  = {r_drem[47:0], r_dlow[31]};
    assign w_qs   = (r_dden == '0) ? 33'sd0 :
                    (r_dneg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq}));
    assign w_qv   = vclamp(w_qs);

    // Move operands
    logic signed [15:0] w_vec;
    logic               w_vneg;
    logic signed [52:0] w_mprod, w_mrnd;
    logic signed [32:0] w_md, w_psum;
    logic signed [31:0] w_psat;

    always_comb begin
        case (r_item.direction)
            DIR_FORWARD:  begin w_vec = r_front[i_cmd.axis]; w_vneg = 1'b0; end
            DIR_BACKWARD: begin w_vec = r_front[i_cmd.axis]; w_vneg = 1'b1; end
            DIR_LEFT:     begin w_vec = r_right[i_cmd.axis]; w_vneg = 1'b1; end
            DIR_RIGHT:    begin w_vec = r_right[i_cmd.axis]; w_vneg = 1'b0; end
            DIR_UP:       begin w_vec = r_up[i_cmd.axis];    w_vneg = 1'b0; end
            DIR_DOWN:     begin w_vec = r_up[i_cmd.axis];    w_vneg = 1'b1; end
            default:      begin w_vec = '0;                  w_vneg = 1'b0; end
        endcase
    end

    assign w_mprod = w_vec * $signed({1'b0, r_vel});
    assign w_mrnd  = r_mprod + 53'sd2097152;
    assign w_md    = {{2{w_mrnd[52]}}, w_mrnd[52:22]};
    assign w_psum  = {r_pos[i_cmd.axis][31], r_pos[i_cmd.axis]} + (w_vneg ? -w_md : w_md);
    assign w_psat  = (w_psum > 33'sd2147483647) ? 32'sh7fffffff :
                     (w_psum < -33'sd2147483648) ? 32'sh80000000 : w_psum[31:0];

    // Rotate operands
    logic signed [40:0] w_yprod, w_pprod;
    logic signed [29:0] w_yt, w_pt;
    logic signed [23:0] w_pclamp;
    logic [24:0]        w_cyaw;
    logic signed [23:0] w_cpitch, w_cfg_p;

    assign w_yprod  = r_item.yaw_offset * $signed({1'b0, r_sens}) + 41'sd2048;
    assign w_pprod  = r_item.pitch_offset * $signed({1'b0, r_sens}) + 41'sd2048;
    assign w_yt     = $signed({5'b0, r_yaw}) + {r_dy[28], r_dy};
    assign w_pt     = {{6{r_pitch[23]}}, r_pitch} + {r_dp[28], r_dp};
    assign w_pclamp = (w_pt > 30'sd5832704) ? PITCH_LIMIT :
                      (w_pt < -30'sd5832704) ? -PITCH_LIMIT : w_pt[23:0];
    assign o_status.yaw_ok = !r_yt[29] && (r_yt < 30'sd23592960);

    // Start register loads
    assign w_cyaw   = (i_cfg_data[24:0] >= YAW_FULL) ? i_cfg_data[24:0] - YAW_FULL
                                                     : i_cfg_data[24:0];
    assign w_cfg_p  = i_cfg_data[23:0];
    assign w_cpitch = (w_cfg_p > PITCH_LIMIT) ? PITCH_LIMIT :
                      (w_cfg_p < -PITCH_LIMIT) ? -PITCH_LIMIT : w_cfg_p;

    // Pose state: configuration, move and rotate updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= SPEED_RESET;
            r_sens  <= SENS_RESET;
            r_yaw   <= '0;
            r_pitch <= '0;
            for (int i = 0; i < 3; i++) r_pos[i] <= '0;
        end else begin
            if (i_cfg_acc) begin
                case (i_cfg_index)
                    CFG_MOVE_SPEED:  r_speed  <= i_cfg_data[15:0];
                    CFG_LOOK_SENS:   r_sens   <= i_cfg_data[15:0];
                    CFG_START_X:     r_pos[0] <= i_cfg_data;
                    CFG_START_Y:     r_pos[1] <= i_cfg_data;
                    CFG_START_Z:     r_pos[2] <= i_cfg_data;
                    CFG_START_YAW:   r_yaw    <= w_cyaw;
                    CFG_START_PITCH: r_pitch  <= w_cpitch;
                    default: ;
                endcase
            end
            if (i_cmd.op == DP_MV_ACC) r_pos[i_cmd.axis] <= w_psat;
            if (i_cmd.op == DP_ROT_ADD) r_pitch <= w_pclamp;
            if (i_cmd.op == DP_ROT_WRAP && o_status.yaw_ok) r_yaw <= r_yt[24:0];
        end
    end

    // Working datapath registers
    always_ff @(posedge i_clk) begin
        if (i_in_acc) r_item <= i_item;
        case (i_cmd.op)
            DP_MV_VEL:  r_vel   <= r_speed * r_item.delta_time;
            DP_MV_MUL:  r_mprod <= w_mprod;
            DP_ROT_MUL: begin
                r_dy <= w_yprod[40:12];
                r_dp <= w_pprod[40:12];
            end
            DP_ROT_ADD: r_yt <= w_yt;
            DP_ROT_WRAP: begin
                if (r_yt[29]) r_yt <= r_yt + 30'sd23592960;
                else if (!o_status.yaw_ok) r_yt <= r_yt - 30'sd23592960;
            end
            DP_CRD_INIT: begin
                for (int l = 0; l < 2; l++) begin
                    r_cx[l]   <= CORDIC_START;
                    r_cy[l]   <= '0;
                    r_cz[l]   <= w_red[l][25:0];
                    r_cneg[l] <= w_red[l][26];
                end
            end
            DP_CRD_STEP: begin
                for (int l = 0; l < 2; l++) begin
                    if (!r_cz[l][25]) begin
                        r_cx[l] <= r_cx[l] - w_ys[l];
                        r_cy[l] <= r_cy[l] + w_xs[l];
                        r_cz[l] <= r_cz[l] - w_atan;
                    end else begin
                        r_cx[l] <= r_cx[l] + w_ys[l];
                        r_cy[l] <= r_cy[l] - w_xs[l];
                        r_cz[l] <= r_cz[l] + w_atan;
                    end
                end
            end
            DP_FX_MUL: r_prod <= w_prod;
            DP_FZ_MUL: begin
                r_fx   <= w_round30;
                r_fy   <= w_sin[1];
                r_prod <= w_prod;
            end
            DP_SQ_X: begin
                r_fz   <= w_round30;
                r_prod <= w_prod;
            end
            DP_SQ_Z: begin
                r_sumh <= r_prod;
                r_prod <= w_prod;
            end
            DP_SQ_Y: begin
                r_sumh <= r_sumh + r_prod;
                r_prod <= w_prod;
            end
            DP_SUM: r_suml <= r_sumh + r_prod;
            DP_SQRT_INIT: begin
                r_sv[0] <= r_sumh;
                r_sv[1] <= r_suml;
                r_sr[0] <= '0;
                r_sr[1] <= '0;
                r_sbit  <= {1'b1, 62'b0};
            end
            DP_SQRT_STEP: begin
                for (int l = 0; l < 2; l++) begin
                    if (r_sv[l] >= w_st[l]) begin
                        r_sv[l] <= r_sv[l] - w_st[l];
                        r_sr[l] <= (r_sr[l] >> 1) + {1'b0, r_sbit};
                    end else begin
                        r_sr[l] <= r_sr[l] >> 1;
                    end
                end
                r_sbit <= r_sbit >> 2;
            end
            DP_UP_MUL: r_prod <= w_prod;
            DP_DIV_START: begin
                r_drem <= {17'b0, w_mag[63:32]};
                r_dlow <= w_mag[31:0];
                r_dden <= w_den;
                r_dneg <= w_num[63];
                r_dq   <= '0;
            end
            DP_DIV_STEP: begin
                if (w_dsh >= {1'b0, r_dden}) begin
                    r_drem <= w_dsh - {1'b0, r_dden};
                    r_dq   <= {r_dq[30:0], 1'b1};
                end else begin
                    r_drem <= w_dsh;
                    r_dq   <= {r_dq[30:0], 1'b0};
                end
                r_dlow <= {r_dlow[30:0], 1'b0};
            end
            DP_DIV_STORE: begin
                case (i_cmd.div)
                    DV_FRONT_X: r_front[0] <= w_qv;
                    DV_FRONT_Y: r_front[1] <= w_qv;
                    DV_FRONT_Z: r_front[2] <= w_qv;
                    DV_RIGHT_X: begin
                        r_right[0] <= w_qv;
                        r_right[1] <= '0;
                    end
                    DV_RIGHT_Z: r_right[2] <= w_qv;
                    DV_A:       r_a        <= w_qs[31:0];
                    DV_C:       r_c        <= w_qs[31:0];
                    DV_UP_Y:    r_up[1]    <= w_qv;
                    DV_UP_X:    r_up[0]    <= w_qv;
                    DV_UP_Z:    r_up[2]    <= w_qv;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // Current pose
    assign o_pose.pos_x   = r_pos[0];
    assign o_pose.pos_y   = r_pos[1];
    assign o_pose.pos_z   = r_pos[2];
    assign o_pose.front_x = r_front[0];
    assign o_pose.front_y = r_front[1];
    assign o_pose.front_z = r_front[2];
    assign o_pose.right_x = r_right[0];
    assign o_pose.right_y = r_right[1];
    assign o_pose.right_z = r_right[2];
    assign o_pose.up_x    = r_up[0];
    assign o_pose.up_y    = r_up[1];
    assign o_pose.up_z    = r_up[2];

`ifndef SYNTHESIS
    a_angles_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_CRD_INIT) |-> (r_yaw < YAW_FULL && r_pitch <= PITCH_LIMIT &&
                                      r_pitch >= -PITCH_LIMIT))
        else $error("basis rebuild started from an out of range angle");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_DIV_STEP && r_dden != '0) |-> (r_drem < {1'b0, r_dden}))
        else $error("divider remainder not below divisor");
    a_wrap_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_ROT_WRAP && !o_status.yaw_ok) |=> (r_yt != $past(r_yt)))
        else $error("yaw wrap made no progress");
`endif

endmodule

FILE: rtl/fly_camera_pose_update_top.sv
// Top level of the fly camera pose update block: sequencer, datapath and result register.
`timescale 1ns / 1ps

// Keeps a first-person camera pose (position, yaw, pitch, front/right/up) and
// returns the new pose for every transfer on the input channel. A move is one
// speed-times-time multiply, then one multiply and one saturating add per axis.
// A rotate scales and adds the offsets, wraps the yaw one full turn at a time,
// then runs the basis rebuild: 16 CORDIC iterations (yaw and pitch lanes
// together), forming and summing the squared lengths on the shared 32x32
// multiplier, 32 square-root steps (both lengths together), ten 32-step
// restoring divisions and two more multiplies for the up vector. Writing
// start_yaw or start_pitch, and leaving reset, runs the same rebuild while both
// the input and configuration channels hold ready low; a waiting register write
// is taken ahead of a waiting input. A finished pose sits in an output register
// so the next item can be taken before it leaves.
module fly_camera_pose_update_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  fcpu_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output fcpu_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import fcpu_pkg::*;

    logic       w_in_acc, w_cfg_acc, w_out_free, w_res_load;
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_out_item  w_pose;
    t_out_item  r_out;
    logic       r_out_valid;

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    fcpu_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_acc    (w_in_acc),
        .i_in_op     (i_in.op),
        .i_in_dir    (i_in.direction),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_acc   (w_cfg_acc),
        .i_cfg_index (i_cfg_index),
        .i_status    (w_status),
        .i_out_free  (w_out_free),
        .o_cmd       (w_cmd),
        .o_in_ready  (o_in_ready),
        .o_cfg_ready (o_cfg_ready),
        .o_res_load  (w_res_load)
    );

    fcpu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in),
        .i_in_acc    (w_in_acc),
        .i_cfg_acc   (w_cfg_acc),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_pose      (w_pose)
    );

    // Result register: holds a pose until its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) r_out <= w_pose;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !o_in_ready)
        else $error("input still ready after a transfer");
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_res_load))
        else $error("result appeared without a load");
    a_front_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.front_x <= 16'sd16384 && o_out.front_x >= -16'sd16384))
        else $error("front vector out of range");
    a_rebuild_blocks_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_acc && i_cfg_index == CFG_START_YAW) |=> !o_cfg_ready)
        else $error("configuration taken during basis rebuild");
`endif

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the fly camera pose update block.
`timescale 1ns / 1ps

// Tracks the expected pose with its own fixed-point camera model; the
// driver feeds moves, rotates and register writes under random back-pressure.
class pose_scoreboard;
    fcpu_pkg::t_out_item pose_q[$];
    int     errors;
    int     n_move;
    int     n_rot;
    longint speed, sens, yaw, pitch;
    longint pos[3], fr[3], rt[3], up[3];

    static function longint rnd_div(longint n, longint d);
        if (d <= 0) return 0;
        if (n >= 0) return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    static function longint vclip(longint v);
        return clip(v, -16384, 16384);
    endfunction

    static function longint unsigned root(longint unsigned v);
        longint unsigned r, bit_v;
        r = 0;
        bit_v = 64'd1 << 62;
        while (bit_v > v) bit_v >>= 2;
        while (bit_v != 0) begin
            if (v >= r + bit_v) begin
                v = v - (r + bit_v);
                r = (r >> 1) + bit_v;
            end else begin
                r = r >> 1;
            end
            bit_v >>= 2;
        end
        return r;
    endfunction

    // Rotation-mode CORDIC after folding the angle into [-90, 90] degrees
    static function void sin_cos(longint ang, output longint c, output longint s);
        longint x, y, z, nx, xs, ys;
        bit     neg;
        x = 652032874;
        y = 0;
        neg = 0;
        if (ang > 11796480) ang = ang - 23592960;
        if (ang > 5898240) begin
            ang = ang - 11796480;
            neg = 1;
        end else if (ang < -5898240) begin
            ang = ang + 11796480;
            neg = 1;
        end
        z = ang;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                nx = x - ys;
                y = y + xs;
                z = z - fcpu_pkg::atan_lut(4'(i));
            end else begin
                nx = x + ys;
                y = y - xs;
                z = z + fcpu_pkg::atan_lut(4'(i));
            end
            x = nx;
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function void rebuild_basis();
        longint cy, sy, cp, sp, fx, fy, fz, ll, hh, a, c;
        sin_cos(yaw, cy, sy);
        sin_cos(pitch, cp, sp);
        fx = (cp * cy + (64'sd1 <<< 29)) >>> 30;
        fy = sp;
        fz = (cp * sy + (64'sd1 <<< 29)) >>> 30;
        ll = root(fx * fx + fy * fy + fz * fz);
        hh = root(fx * fx + fz * fz);
        fr[0] = vclip(rnd_div(fx * 16384, ll));
        fr[1] = vclip(rnd_div(fy * 16384, ll));
        fr[2] = vclip(rnd_div(fz * 16384, ll));
        rt[0] = vclip(rnd_div(-fz * 16384, hh));
        rt[1] = 0;
        rt[2] = vclip(rnd_div(fx * 16384, hh));
        a = rnd_div(fx * (64'sd1 <<< 30), hh);
        c = rnd_div(fz * (64'sd1 <<< 30), hh);
        up[0] = vclip(rnd_div(-(a * fy), ll * 65536));
        up[1] = vclip(rnd_div(hh * 16384, ll));
        up[2] = vclip(rnd_div(-(c * fy), ll * 65536));
    endfunction

    function void reset_state();
        speed = fcpu_pkg::SPEED_RESET;
        sens = fcpu_pkg::SENS_RESET;
        yaw = 0;
        pitch = 0;
        for (int i = 0; i < 3; i++) pos[i] = 0;
        rebuild_basis();
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            fcpu_pkg::CFG_MOVE_SPEED:  speed = data[15:0];
            fcpu_pkg::CFG_LOOK_SENS:   sens = data[15:0];
            fcpu_pkg::CFG_START_X:     pos[0] = $signed(data);
            fcpu_pkg::CFG_START_Y:     pos[1] = $signed(data);
            fcpu_pkg::CFG_START_Z:     pos[2] = $signed(data);
            fcpu_pkg::CFG_START_YAW: begin
                yaw = longint'(data[24:0]) % 23592960;
                rebuild_basis();
            end
            fcpu_pkg::CFG_START_PITCH: begin
                pitch = clip($signed(data[23:0]), -5832704, 5832704);
                rebuild_basis();
            end
            default: ;
        endcase
    endfunction

    // Apply one accepted input to the pose and queue the pose it leads to
    function void note_input(fcpu_pkg::t_in_item it);
        fcpu_pkg::t_out_item p;
        longint vel, sgn, d, t, dy, dp;
        longint vec[3];
        if (it.op == fcpu_pkg::OP_MOVE) begin
            n_move++;
            vel = speed * longint'(it.delta_time);
            vec = fr;
            sgn = 1;
            if (it.direction <= fcpu_pkg::DIR_DOWN) begin
                if (it.direction == fcpu_pkg::DIR_LEFT || it.direction == fcpu_pkg::DIR_RIGHT)
                    vec = rt;
                else if (it.direction == fcpu_pkg::DIR_UP || it.direction == fcpu_pkg::DIR_DOWN)
                    vec = up;
                if (it.direction == fcpu_pkg::DIR_BACKWARD || it.direction == fcpu_pkg::DIR_LEFT
                    || it.direction == fcpu_pkg::DIR_DOWN)
                    sgn = -1;
                for (int i = 0; i < 3; i++) begin
                    d = (vec[i] * vel + (64'sd1 <<< 21)) >>> 22;
                    pos[i] = clip(pos[i] + sgn * d, -64'sd2147483648, 64'sd2147483647);
                end
            end
        end else begin
            n_rot++;
            dy = (longint'(it.yaw_offset) * sens + 2048) >>> 12;
            dp = (longint'(it.pitch_offset) * sens + 2048) >>> 12;
            t = (yaw + dy) % 23592960;
            if (t < 0) t = t + 23592960;
            yaw = t;
            pitch = clip(pitch + dp, -5832704, 5832704);
            rebuild_basis();
        end
        p.pos_x = 32'(pos[0]);
        p.pos_y = 32'(pos[1]);
        p.pos_z = 32'(pos[2]);
        p.front_x = 16'(fr[0]);
        p.front_y = 16'(fr[1]);
        p.front_z = 16'(fr[2]);
        p.right_x = 16'(rt[0]);
        p.right_y = 16'(rt[1]);
        p.right_z = 16'(rt[2]);
        p.up_x = 16'(up[0]);
        p.up_y = 16'(up[1]);
        p.up_z = 16'(up[2]);
        pose_q.push_back(p);
    endfunction

    function void cmp(string name, longint e, longint a);
        if (e != a) begin
            errors++;
            $error("field %s: expected %0d, got %0d", name, e, a);
        end
    endfunction

    function void check_result(fcpu_pkg::t_out_item a);
        fcpu_pkg::t_out_item e;
        if (pose_q.size() == 0) begin
            errors++;
            $error("pose transfer with nothing outstanding");
            return;
        end
        e = pose_q.pop_front();
        cmp("pos_x", e.pos_x, a.pos_x);
        cmp("pos_y", e.pos_y, a.pos_y);
        cmp("pos_z", e.pos_z, a.pos_z);
        cmp("front_x", e.front_x, a.front_x);
        cmp("front_y", e.front_y, a.front_y);
        cmp("front_z", e.front_z, a.front_z);
        cmp("right_x", e.right_x, a.right_x);
        cmp("right_y", e.right_y, a.right_y);
        cmp("right_z", e.right_z, a.right_z);
        cmp("up_x", e.up_x, a.up_x);
        cmp("up_y", e.up_y, a.up_y);
        cmp("up_z", e.up_z, a.up_z);
    endfunction
endclass

module testbench;
    import fcpu_pkg::*;

    localparam int          STALL_LIMIT = 20000;
    localparam logic [2:0]  CFG_UNUSED  = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    pose_scoreboard sb;
    bit          calm = 1'b0;
    int          stall_cnt = 0;
    int          n_cfg = 0;

    fly_camera_pose_update_top u_top (.*);

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Result side: random back-pressure, and every pose transfer is checked
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out);
        i_out_ready <= calm || ($urandom_range(0, 99) >= 7);
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic send_item(t_in_item it);
        if (!calm && $urandom_range(0, 99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in <= it;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pose_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        n_cfg++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_item mk_move(logic [2:0] dir, logic [19:0] dt);
        t_in_item it;
        it = '0;
        it.op = OP_MOVE;
        it.direction = dir;
        it.delta_time = dt;
        it.yaw_offset = 24'($urandom);
        it.pitch_offset = 24'($urandom);
        return it;
    endfunction

    function automatic t_in_item mk_rot(logic [23:0] yo, logic [23:0] po);
        t_in_item it;
        it.op = OP_ROTATE;
        it.direction = 3'($urandom);
        it.delta_time = 20'($urandom);
        it.yaw_offset = yo;
        it.pitch_offset = po;
        return it;
    endfunction

    // Mostly valid directions, moderate times, with full-range fields now and then
    function automatic t_in_item rand_item();
        logic [19:0] dt;
        logic [23:0] yo, po;
        dt = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 8191));
        yo = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($signed($urandom_range(0, 131071)) - 65536);
        po = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($signed($urandom_range(0, 131071)) - 65536);
        if ($urandom_range(0, 1) == 0)
            return mk_move(($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                       : 3'($urandom_range(0, 5)), dt);
        return mk_rot(yo, po);
    endfunction

    function automatic logic [31:0] pick(logic [31:0] lo, logic [31:0] hi);
        case ($urandom_range(0, 3))
            0:       return lo;
            1:       return hi;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        sb = new();
        sb.reset_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every direction at full time, forward at zero time, unused codes, extreme offsets
        for (int d = 0; d < 8; d++) send_item(mk_move(3'(d), 20'hFFFFF));
        send_item(mk_move(DIR_FORWARD, 20'd0));
        send_item(mk_rot(24'h7FFFFF, 24'h7FFFFF));
        send_item(mk_rot(24'h800000, 24'h800000));
        send_item(mk_rot(24'h800000, 24'h7FFFFF));
        send_item(mk_rot(24'd0, 24'd0));
        for (int d = 0; d < 6; d++) send_item(mk_move(3'(d), 20'h10000));
        send_item(mk_rot(24'hFFFFFF, 24'hFFFFFF));
        drain();

        // Extreme settings: saturation of position, clamped pitch, yaw above a full turn
        write_cfg(CFG_MOVE_SPEED, 32'hFFFF);
        write_cfg(CFG_LOOK_SENS, 32'hFFFF);
        write_cfg(CFG_START_X, 32'h7FFF_0000);
        write_cfg(CFG_START_Y, 32'h8000_0000);
        write_cfg(CFG_START_Z, 32'h7FFF_FFFF);
        write_cfg(CFG_START_YAW, 32'h01FF_FFFF);
        write_cfg(CFG_START_PITCH, 32'h0080_0000);
        write_cfg(CFG_UNUSED, 32'hFFFF_FFFF);
        for (int d = 0; d < 6; d++) send_item(mk_move(3'(d), 20'hFFFFF));

        // Random phases, each behind a fresh set of registers
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_cfg(CFG_MOVE_SPEED, pick(32'd0, 32'hFFFF));
            write_cfg(CFG_LOOK_SENS, pick(32'd0, 32'hFFFF));
            write_cfg(CFG_START_X, pick(32'h8000_0000, 32'h7FFF_FFFF));
            write_cfg(CFG_START_Y, pick(32'h8000_0000, 32'h7FFF_FFFF));
            write_cfg(CFG_START_Z, pick(32'd0, 32'h7FFF_FFFF));
            write_cfg(CFG_START_YAW, pick(32'd0, 32'd23592959));
            write_cfg(CFG_START_PITCH, pick(32'hFFA7_0000, 32'd5832704));
            for (int n = 0; n < 120; n++) begin
                calm = (ph == 2);
                // Hold off until the block has emptied, once in the middle
                if (ph == 3 && n == 60) drain();
                send_item(rand_item());
            end
            calm = 1'b0;
        end

        drain();
        repeat (600) @(posedge i_clk);
        $display("covered %0d moves, %0d rotates and %0d register writes", sb.n_move,
                 sb.n_rot, n_cfg);
        $display("under random stalls on both channels, including saturation and clamping");
        if (sb.errors == 0 && sb.pose_q.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

FILE: sim.f
rtl/fcpu_pkg.sv
rtl/fcpu_ctrl.sv
rtl/fcpu_dp.sv
rtl/fly_camera_pose_update_top.sv
tb/sv/testbench.sv
